[design/fst_pkg.sv]
// Shared types, codes and constants of the flow statistics table.
`timescale 1ns / 1ps

package fst_pkg;

  localparam int unsigned FLOW_ENTRIES_DEF = 64;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_UPD      = 3'd1,
    ST_IGN      = 3'd2,
    ST_FULL     = 3'd3,
    ST_RD_OK    = 3'd4,
    ST_RD_EMPTY = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    TK_TCP   = 2'd0,
    TK_UDP   = 2'd1,
    TK_OTHER = 2'd2
  } transport_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_ALLOC,
    S_READ,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic        action;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        is_ipv4;
    logic [1:0]  transport_kind;
    logic        addr_present;
    logic [17:0] frame_length;
    logic [47:0] timestamp;
    logic [5:0]  entry_index;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  flow_index;
    logic [31:0] flow_src_addr;
    logic [31:0] flow_dst_addr;
    logic [15:0] flow_src_port;
    logic [15:0] flow_dst_port;
    logic        flow_is_udp;
    logic [31:0] flow_packets;
    logic [47:0] flow_bytes;
    logic [47:0] flow_first_seen;
    logic [47:0] flow_last_seen;
  } rsp_t;

  // One table row as it is stored in the memory.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        udp;
    logic [31:0] packets;
    logic [47:0] bytes;
    logic [47:0] first;
    logic [47:0] last;
  } entry_t;

  function automatic rsp_t make_rsp(status_e st, logic [5:0] idx, entry_t e);
    rsp_t r;
    r.status          = st;
    r.flow_index      = idx;
    r.flow_src_addr   = e.src;
    r.flow_dst_addr   = e.dst;
    r.flow_src_port   = e.sport;
    r.flow_dst_port   = e.dport;
    r.flow_is_udp     = e.udp;
    r.flow_packets    = e.packets;
    r.flow_bytes      = e.bytes;
    r.flow_first_seen = e.first;
    r.flow_last_seen  = e.last;
    return r;
  endfunction

endpackage

[design/fst_intf.sv]
// Valid/ready channel interfaces for requests and responses of the flow table.
`timescale 1ns / 1ps

interface fst_req_if import fst_pkg::*; ();
  logic valid;
  logic ready;
  req_t req;

  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

interface fst_rsp_if import fst_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t rsp;

  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

[design/flow_statistics_table_top.sv]
// Top level of the five-tuple flow statistics table.
`timescale 1ns / 1ps

// Flow statistics table. Each request either accounts one packet against the
// table or reads one row back; every request yields exactly one response. The
// rows live in a single memory with one write port and one registered read
// port, and rows fill in arrival order, so the fill count alone tells which
// rows are valid and no clearing pass is needed after reset. A packet request
// searches the filled rows one per cycle through that read port. One request
// is handled at a time; a new one is taken while the previous response still
// waits in the output register.
module flow_statistics_table_top import fst_pkg::*; #(
  parameter int unsigned FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fst_req_if.sink       req_i,
  fst_rsp_if.source     rsp_o
);

  localparam int unsigned IdxW = $clog2(FLOW_ENTRIES);
  localparam int unsigned CntW = $clog2(FLOW_ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > 6) ? CntW : 6;

  fsm_e            state_q, state_d;
  req_t            req_q;
  rsp_t            res_q, res_d;
  rsp_t            out_q;
  logic            out_valid_q;
  entry_t          hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic            pend_q;
  logic [IdxW-1:0] pidx_q;

  entry_t          mem [FLOW_ENTRIES];
  entry_t          rdata_q;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [IdxW-1:0] raddr;
  entry_t          wdata;

  logic            accept;
  logic            ignored;
  logic            issue;
  logic            match;
  logic            load;
  logic [CmpW-1:0] rd_idx_ext;
  entry_t          upd_entry;
  entry_t          new_entry;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.rsp   = out_q;

  assign ignored = !req_i.req.is_ipv4 || !req_i.req.addr_present ||
                   !((req_i.req.transport_kind == TK_TCP) ||
                     (req_i.req.transport_kind == TK_UDP));
  assign rd_idx_ext = CmpW'(req_i.req.entry_index);

  // The memory output is registered, so a compare belongs to
  // the row that was issued in the previous cycle.
  assign match = pend_q &&
                 (rdata_q.src == req_q.src_addr) && (rdata_q.dst == req_q.dst_addr) &&
                 (rdata_q.sport == req_q.src_port) &&
                 (rdata_q.dport == req_q.dst_port) &&
                 (rdata_q.udp == req_q.transport_kind[0]);

  always_comb begin
    new_entry         = '0;
    new_entry.src     = req_q.src_addr;
    new_entry.dst     = req_q.dst_addr;
    new_entry.sport   = req_q.src_port;
    new_entry.dport   = req_q.dst_port;
    new_entry.udp     = req_q.transport_kind[0];
    new_entry.packets = 32'd1;
    new_entry.bytes   = 48'(req_q.frame_length);
    new_entry.first   = req_q.timestamp;
    new_entry.last    = req_q.timestamp;
  end

  fst_stat_upd u_stat_upd (
    .cur_i (hit_q),
    .len_i (req_q.frame_length),
    .ts_i  (req_q.timestamp),
    .nxt_o (upd_entry)
  );

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    fill_d    = fill_q;
    scan_d    = scan_q;
    issue     = 1'b0;
    load      = 1'b0;
    we        = 1'b0;
    waddr     = hit_idx_q;
    wdata     = upd_entry;
    raddr     = scan_q[IdxW-1:0];
    unique case (state_q)
      S_IDLE: begin
        raddr = rd_idx_ext[IdxW-1:0];
        if (accept) begin
          if (req_i.req.action) begin
            if (rd_idx_ext < CmpW'(fill_q)) begin
              state_d = S_READ;
            end else begin
              res_d   = make_rsp(ST_RD_EMPTY, req_i.req.entry_index, '0);
              state_d = S_DONE;
            end
          end else if (ignored) begin
            res_d   = make_rsp(ST_IGN, 6'd0, '0);
            state_d = S_DONE;
          end else begin
            scan_d  = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_d     = rdata_q;
          hit_idx_d = pidx_q;
          state_d   = S_UPDATE;
        end else if (scan_q < fill_q) begin
          issue  = 1'b1;
          scan_d = scan_q + CntW'(1);
        end else if (!pend_q) begin
          if (fill_q == CntW'(FLOW_ENTRIES)) begin
            res_d   = make_rsp(ST_FULL, 6'd0, '0);
            state_d = S_DONE;
          end else begin
            state_d = S_ALLOC;
          end
        end
      end
      S_UPDATE: begin
        we      = 1'b1;
        waddr   = hit_idx_q;
        wdata   = upd_entry;
        res_d   = make_rsp(ST_UPD, 6'(CmpW'(hit_idx_q)), upd_entry);
        state_d = S_DONE;
      end
      S_ALLOC: begin
        we      = 1'b1;
        waddr   = fill_q[IdxW-1:0];
        wdata   = new_entry;
        fill_d  = fill_q + CntW'(1);
        res_d   = make_rsp(ST_NEW, 6'(CmpW'(fill_q)), new_entry);
        state_d = S_DONE;
      end
      S_READ: begin
        res_d   = make_rsp(ST_RD_OK, req_q.entry_index, rdata_q);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      scan_q  <= scan_d;
      pend_q  <= issue;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i.req;
    end
    if (load) begin
      out_q <= res_q;
    end
    res_q     <= res_d;
    hit_q     <= hit_d;
    hit_idx_q <= hit_idx_d;
    pidx_q    <= scan_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(FLOW_ENTRIES))
    else $error("fill count beyond table size");

  a_alloc_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) |=> (fill_q == $past(fill_q) + CntW'(1)))
    else $error("allocation did not advance the fill count");

  a_hit_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |-> (CntW'(hit_idx_q) < fill_q))
    else $error("update of a row that was never filled");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCAN))
    else $error("row compare pending outside the search");
`endif

endmodule

[design/fst_stat_upd.sv]
// Saturating counter and time window update of one matched table row.
`timescale 1ns / 1ps

module fst_stat_upd import fst_pkg::*; (
  input  entry_t      cur_i,
  input  logic [17:0] len_i,
  input  logic [47:0] ts_i,
  output entry_t      nxt_o
);

  logic [48:0] byte_sum;

  assign byte_sum = {1'b0, cur_i.bytes} + 49'(len_i);

  always_comb begin
    nxt_o = cur_i;
    if (cur_i.packets != '1) begin
      nxt_o.packets = cur_i.packets + 32'd1;
    end
    nxt_o.bytes = byte_sum[48] ? '1 : byte_sum[47:0];
    if (ts_i < cur_i.first) begin
      nxt_o.first = ts_i;
    end
    if (ts_i > cur_i.last) begin
      nxt_o.last = ts_i;
    end
  end

endmodule
